[rtl/agaf_pkg.sv]
package agaf_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int GAP_W       = 16;
  localparam int MS_W        = 16;
  localparam int CNT_W       = 11;
  localparam int WIDE_W      = 32;
  localparam int MAX_LEN_DEF = 1024;

  // APB register file: seven 32-bit registers at 4-byte spacing
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam int IN_RAW_W  = MS_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 2 * SCORE_BITS + 2 + 2 * CNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic signed [GAP_W-1:0]      gap_t;
  typedef logic signed [MS_W-1:0]       ms_t;
  typedef logic        [CNT_W-1:0]      count_t;
  typedef logic signed [WIDE_W-1:0]     wide_t;

  typedef enum logic [1:0] {
    TRACE_HGAP  = 2'd0,
    TRACE_VGAP  = 2'd1,
    TRACE_MATCH = 2'd2
  } trace_e;

  typedef enum logic [2:0] {
    REG_ROW_GAP_OPEN   = 3'd0,
    REG_ROW_GAP_EXTEND = 3'd1,
    REG_COL_GAP_OPEN   = 3'd2,
    REG_COL_GAP_EXTEND = 3'd3,
    REG_END_GAP_MODE   = 3'd4,
    REG_ROW_COUNT      = 3'd5,
    REG_COL_COUNT      = 3'd6
  } reg_idx_e;

  // end_gap_mode bit positions
  localparam int MODE_ROW_LEFT  = 0;
  localparam int MODE_ROW_RIGHT = 1;
  localparam int MODE_COL_LEFT  = 2;
  localparam int MODE_COL_RIGHT = 3;

  localparam gap_t       RST_GAP_OPEN   = GAP_W'(-10);
  localparam gap_t       RST_GAP_EXTEND = GAP_W'(-1);
  localparam logic [3:0] RST_MODE       = 4'hF;
  localparam count_t     RST_COUNT      = CNT_W'(1);
  localparam score_t     START_BEST     = SCORE_BITS'(-9999);

  function automatic score_t sat_score(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (SCORE_BITS - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return score_t'(hi);
    end else if (v < lo) begin
      return score_t'(lo);
    end
    return score_t'(v);
  endfunction

endpackage

[rtl/agaf_ram.sv]
module agaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-during-write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/affine_gap_global_align_fill_top.sv]
// Gotoh affine-gap global alignment matrix fill. Feed one substitution score per cell in
// row-major order (row 1..row_count, column 1..col_count); each item returns the cell score,
// its trace code, and the best eligible end score with its position, with tlast on the final
// cell, after which the position and best score start over. One cell is taken per cycle while
// the output is not stalled; each item passes a stage that reads the column store and
// forms the border values (two small multipliers), a stage that computes the cell scores and
// writes them back, a stage to the best-score tracker, and the output register. The column
// store is one RAM of MAX_LEN entries holding the match and gap score of the row above; a
// single-column matrix rereads an entry the cycle it is written, which a bypass register
// covers. There is no clearing pass: the top row uses border values, not the store contents.
// Configuration is to be written only while no item is in flight; the block does not enforce it.
module affine_gap_global_align_fill_top
  import agaf_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // match_score [15:0]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [agaf_pkg::IN_W-1:0]    s_axis_tdata,
  // cell_score [15:0], trace_code [17:16], best_score [33:18], best_row [44:34],
  // best_col [55:45]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [agaf_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [agaf_pkg::CFG_AW-1:0]  paddr,
  input  logic [agaf_pkg::CFG_DW-1:0]  pwdata,
  output logic [agaf_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int RAM_W = 2 * SCORE_BITS;

  // ---------------------------------------------------------------- config
  gap_t       rgo_q, rge_q, cgo_q, cge_q;
  logic [3:0] mode_q;
  count_t     rows_q, cols_q;
  count_t     rows_eff, cols_eff;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgo_q  <= RST_GAP_OPEN;
      rge_q  <= RST_GAP_EXTEND;
      cgo_q  <= RST_GAP_OPEN;
      cge_q  <= RST_GAP_EXTEND;
      mode_q <= RST_MODE;
      rows_q <= RST_COUNT;
      cols_q <= RST_COUNT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_GAP_OPEN:   rgo_q  <= pwdata[GAP_W-1:0];
        REG_ROW_GAP_EXTEND: rge_q  <= pwdata[GAP_W-1:0];
        REG_COL_GAP_OPEN:   cgo_q  <= pwdata[GAP_W-1:0];
        REG_COL_GAP_EXTEND: cge_q  <= pwdata[GAP_W-1:0];
        REG_END_GAP_MODE:   mode_q <= pwdata[3:0];
        REG_ROW_COUNT:      rows_q <= pwdata[CNT_W-1:0];
        REG_COL_COUNT:      cols_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW_GAP_OPEN:   prdata = {{(CFG_DW-GAP_W){1'b0}}, rgo_q};
      REG_ROW_GAP_EXTEND: prdata = {{(CFG_DW-GAP_W){1'b0}}, rge_q};
      REG_COL_GAP_OPEN:   prdata = {{(CFG_DW-GAP_W){1'b0}}, cgo_q};
      REG_COL_GAP_EXTEND: prdata = {{(CFG_DW-GAP_W){1'b0}}, cge_q};
      REG_END_GAP_MODE:   prdata = {{(CFG_DW-4){1'b0}}, mode_q};
      REG_ROW_COUNT:      prdata = {{(CFG_DW-CNT_W){1'b0}}, rows_q};
      REG_COL_COUNT:      prdata = {{(CFG_DW-CNT_W){1'b0}}, cols_q};
      default:            prdata = '0;
    endcase
  end

  // count of zero acts as one, counts clamp at the store depth
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = count_t'(1);
    end else if (32'(rows_q) > 32'(MAX_LEN)) begin
      rows_eff = count_t'(MAX_LEN);
    end else begin
      rows_eff = rows_q;
    end
    if (cols_q == '0) begin
      cols_eff = count_t'(1);
    end else if (32'(cols_q) > 32'(MAX_LEN)) begin
      cols_eff = count_t'(MAX_LEN);
    end else begin
      cols_eff = cols_q;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic v1_q, v2_q, v3_q, vo_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic mv1, mv2, mv3, acc;

  assign out_free = !vo_q || m_axis_tready;
  assign mv3      = v3_q && out_free;
  assign s3_free  = !v3_q || mv3;
  assign mv2      = v2_q && s3_free;
  assign s2_free  = !v2_q || mv2;
  assign mv1      = v1_q && s2_free;
  assign s1_free  = !v1_q || mv1;

  assign s_axis_tready = s1_free;
  assign acc           = s_axis_tvalid && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (s1_free)  v1_q <= s_axis_tvalid;
      if (s2_free)  v2_q <= v1_q;
      if (s3_free)  v3_q <= v2_q;
      if (out_free) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------- position
  count_t row_q, col_q;
  logic   col_end, row_end;

  assign col_end = col_q >= cols_eff;
  assign row_end = row_q >= rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= RST_COUNT;
      col_q <= RST_COUNT;
    end else if (acc) begin
      if (col_end) begin
        col_q <= count_t'(1);
        row_q <= row_end ? count_t'(1) : row_q + count_t'(1);
      end else begin
        col_q <= col_q + count_t'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: store read, borders
  ms_t    s1_ms_q;
  count_t s1_row_q, s1_col_q;
  logic   s1_fcol_q, s1_frow_q, s1_elig_q, s1_last_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ms_q   <= s_axis_tdata[MS_W-1:0];
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_fcol_q <= col_q == count_t'(1);
      s1_frow_q <= row_q == count_t'(1);
      s1_elig_q <= !((mode_q[MODE_ROW_RIGHT] && row_q < rows_eff) ||
                     (mode_q[MODE_COL_RIGHT] && col_q < cols_eff));
      s1_last_q <= col_end && row_end;
    end
  end

  logic signed [GAP_W+CNT_W:0] prod_col_gap, prod_row_gap;
  score_t   lb, db, tb;
  score_t   left_init, gap_init, diag_init, top_m, top_g;
  logic [31:0] s1_col_m1;
  logic [AW-1:0] s1_slot;

  assign s1_col_m1 = 32'(s1_col_q) - 32'd1;
  assign s1_slot   = s1_col_m1[AW-1:0];

  assign prod_col_gap = cge_q * $signed({1'b0, s1_row_q});
  assign prod_row_gap = rge_q * $signed({1'b0, s1_col_q});

  always_comb begin
    lb = sat_score(wide_t'(cgo_q) + wide_t'(prod_col_gap));
    db = sat_score(wide_t'(prod_col_gap) - wide_t'(cge_q) +
                   ((s1_row_q > count_t'(1)) ? wide_t'(cgo_q) : wide_t'(0)));
    tb = sat_score(wide_t'(rgo_q) + wide_t'(prod_row_gap));
    if (mode_q[MODE_COL_LEFT]) begin
      left_init = lb;
      gap_init  = lb;
      diag_init = db;
    end else begin
      left_init = '0;
      gap_init  = sat_score(wide_t'(cgo_q));
      diag_init = '0;
    end
    if (mode_q[MODE_ROW_LEFT]) begin
      top_m = tb;
      top_g = tb;
    end else begin
      top_m = '0;
      top_g = sat_score(wide_t'(rgo_q));
    end
  end

  // ---------------------------------------------------------------- stage 2: cell scores
  ms_t    s2_ms_q;
  count_t s2_row_q, s2_col_q;
  logic   s2_fcol_q, s2_frow_q, s2_elig_q, s2_last_q;
  score_t s2_left_init_q, s2_gap_init_q, s2_diag_init_q, s2_top_m_q, s2_top_g_q;
  logic   fwd_hit_q;
  score_t fwd_m_q, fwd_g_q;
  score_t left_q, gap_q, diag_q;

  logic [31:0]    s2_col_m1;
  logic [AW-1:0]  s2_slot;
  logic [RAM_W-1:0] ram_rdata;
  score_t mem_m, mem_g, above, above_gap, left_u, gap_u, diag_u;
  score_t e1, e2, e, d1, d2, d, c0, c;
  trace_e trace;
  wide_t  cgo_cge, rgo_rge;

  assign s2_col_m1 = 32'(s2_col_q) - 32'd1;
  assign s2_slot   = s2_col_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_ms_q        <= s1_ms_q;
      s2_row_q       <= s1_row_q;
      s2_col_q       <= s1_col_q;
      s2_fcol_q      <= s1_fcol_q;
      s2_frow_q      <= s1_frow_q;
      s2_elig_q      <= s1_elig_q;
      s2_last_q      <= s1_last_q;
      s2_left_init_q <= left_init;
      s2_gap_init_q  <= gap_init;
      s2_diag_init_q <= diag_init;
      s2_top_m_q     <= top_m;
      s2_top_g_q     <= top_g;
      fwd_m_q        <= c;
      fwd_g_q        <= d;
    end
  end

  // the RAM read and the write-back of the same entry land on one edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (mv1) begin
      fwd_hit_q <= mv2 && (s1_slot == s2_slot);
    end
  end

  agaf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_LEN)
  ) u_col_store (
    .clk_i   (clk_i),
    .we_i    (mv2),
    .waddr_i (s2_slot),
    .wdata_i ({d, c}),
    .re_i    (mv1),
    .raddr_i (s1_slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cgo_cge   = wide_t'(cgo_q) + wide_t'(cge_q);
    rgo_rge   = wide_t'(rgo_q) + wide_t'(rge_q);
    mem_m     = fwd_hit_q ? fwd_m_q : $signed(ram_rdata[SCORE_BITS-1:0]);
    mem_g     = fwd_hit_q ? fwd_g_q : $signed(ram_rdata[RAM_W-1:SCORE_BITS]);
    above     = s2_frow_q ? s2_top_m_q : mem_m;
    above_gap = s2_frow_q ? s2_top_g_q : mem_g;
    left_u    = s2_fcol_q ? s2_left_init_q : left_q;
    gap_u     = s2_fcol_q ? s2_gap_init_q  : gap_q;
    diag_u    = s2_fcol_q ? s2_diag_init_q : diag_q;

    e1 = sat_score(wide_t'(left_u) + cgo_cge);
    e2 = sat_score(wide_t'(gap_u) + wide_t'(cge_q));
    e  = (e1 > e2) ? e1 : e2;
    d1 = sat_score(wide_t'(above) + rgo_rge);
    d2 = sat_score(wide_t'(above_gap) + wide_t'(rge_q));
    d  = (d1 > d2) ? d1 : d2;
    c0 = sat_score(wide_t'(diag_u) + wide_t'(s2_ms_q));
    c  = c0;
    if (e > c) c = e;
    if (d > c) c = d;

    if (c == d) begin
      trace = TRACE_HGAP;
    end else if (c == e) begin
      trace = TRACE_VGAP;
    end else begin
      trace = TRACE_MATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      gap_q  <= '0;
      diag_q <= '0;
    end else if (mv2) begin
      left_q <= c;
      gap_q  <= e;
      diag_q <= above;
    end
  end

  // ---------------------------------------------------------------- stage 3: best tracking
  score_t s3_c_q;
  trace_e s3_trace_q;
  logic   s3_elig_q, s3_last_q;
  count_t s3_row_q, s3_col_q;

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      s3_c_q     <= c;
      s3_trace_q <= trace;
      s3_elig_q  <= s2_elig_q;
      s3_last_q  <= s2_last_q;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
    end
  end

  score_t best_q, best_n;
  count_t brow_q, bcol_q, brow_n, bcol_n;
  logic   best_upd;

  assign best_upd = s3_elig_q && (best_q < s3_c_q);
  assign best_n   = best_upd ? s3_c_q   : best_q;
  assign brow_n   = best_upd ? s3_row_q : brow_q;
  assign bcol_n   = best_upd ? s3_col_q : bcol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= START_BEST;
      brow_q <= '0;
      bcol_q <= '0;
    end else if (mv3) begin
      best_q <= s3_last_q ? START_BEST : best_n;
      brow_q <= s3_last_q ? '0 : brow_n;
      bcol_q <= s3_last_q ? '0 : bcol_n;
    end
  end

  // ---------------------------------------------------------------- output register
  score_t     out_c_q, out_best_q;
  logic [1:0] out_trace_q;
  count_t     out_brow_q, out_bcol_q;
  logic       out_last_q;

  always_ff @(posedge clk_i) begin
    if (mv3) begin
      out_c_q     <= s3_c_q;
      out_trace_q <= s3_trace_q;
      out_best_q  <= best_n;
      out_brow_q  <= brow_n;
      out_bcol_q  <= bcol_n;
      out_last_q  <= s3_last_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_W'({out_bcol_q, out_brow_q, out_best_q, out_trace_q, out_c_q});

`ifndef SYNTHESIS
  // input stalls only when every stage is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // the bypass is only needed when consecutive cells share column 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && fwd_hit_q) |-> (s2_col_q == count_t'(1)))
    else $error("column store bypass taken outside the single-column case");

  // a best position is either unset or has both coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[44:34] == '0) == (m_axis_tdata[55:45] == '0)))
    else $error("best position half set");
`endif

endmodule
